// ===== rtl/core/printable_run_extractor_core_assert.svh =====
// Assertion macros for the printable run extractor core.
// PRX_ASSERT_IMPL checks a same-cycle implication, PRX_ASSERT_NEXT a next-cycle one.
`ifndef PRINTABLE_RUN_EXTRACTOR_CORE_ASSERT_SVH
`define PRINTABLE_RUN_EXTRACTOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define PRX_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prx assertion failed");
`define PRX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prx assertion failed");
`else
`define PRX_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PRX_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/prx_pkg.sv =====
package prx_pkg;

   localparam int MAX_MIN_LENGTH_DEF = 63;
   localparam int CMD_FIFO_DEPTH_DEF = 4;

   localparam int MIN_LEN_W = 6;
   localparam int DATA_W    = 8;
   localparam int RUN_CNT_W = 7;

   localparam logic [RUN_CNT_W-1:0] RUN_CNT_MAX      = 7'd127;
   localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RESET = 6'd4;

   localparam logic [DATA_W-1:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [DATA_W-1:0] CHAR_TAB      = 8'h09;
   localparam logic [DATA_W-1:0] PRINTABLE_LO  = 8'h20;
   localparam logic [DATA_W-1:0] PRINTABLE_HI  = 8'h7E;

   // Commands passed from the classifier to the emitter.
   typedef enum logic [1:0] {
      CMD_STORE,   // write data into the hold memory at index count
      CMD_CHAR,    // emit data as the only result of the request
      CMD_DRAIN    // emit count held bytes, then data as the last result
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [DATA_W-1:0]      data;
      logic [MIN_LEN_W-1:0]   count;
   } cmd_type;

   function automatic logic is_printable(input logic [DATA_W-1:0] c);
      return ((c >= PRINTABLE_LO) && (c <= PRINTABLE_HI)) || (c == CHAR_TAB);
   endfunction

endpackage

// ===== rtl/core/printable_run_extractor_core.sv =====
// Printable run extractor: takes one byte per request and passes on only runs
// of printable bytes (0x20..0x7E or tab) at least min_length long, each ended
// by a newline (0x0A); rsp_last marks the final result of a request. The first
// min_length bytes of a run are held in an on-chip memory and released in one
// burst when the run grows one byte longer, or, if the run ends at exactly
// min_length, released followed by a newline. A request with req_end_of_stream
// set closes a pending run the same way. The front end classifies each request
// combinationally and queues one command for the back end; a request that
// causes nothing queues nothing. The back end takes one command per cycle, an
// emitting one only while the result register advances; a flush emits its
// held bytes one per cycle through the hold memory's single read port, then
// its last result. Requests are taken at one per cycle until the command queue
// (CMD_FIFO_DEPTH entries) fills; results leave at up to one per cycle.
// min_length reads 0 as 1; the user must write it only while idle (unenforced).
`include "printable_run_extractor_core_assert.svh"

module printable_run_extractor_core
   import prx_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = MAX_MIN_LENGTH_DEF,
   parameter int CMD_FIFO_DEPTH = CMD_FIFO_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_write_en,
   input  logic [MIN_LEN_W-1:0] csr_min_length,
   // request channel
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [DATA_W-1:0]    req_data_byte,
   input  logic                 req_end_of_stream,
   // result channel
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [DATA_W-1:0]    rsp_out_char,
   output logic                 rsp_last
);

   logic                 cmd_push;
   cmd_type              cmd_push_data;
   logic                 cmd_full;
   logic                 cmd_valid;
   cmd_type              cmd_head;
   logic                 cmd_pop;
   logic [RUN_CNT_W-1:0] run_count;
   logic                 req_take;

   // A request is taken on this edge.
   assign req_take = req_push && !req_full;

   // Classify requests, track run length, hold the configuration.
   prx_front #(
      .MAX_MIN_LENGTH (MAX_MIN_LENGTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_min_length    (csr_min_length),
      .req_push          (req_push),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .req_full          (req_full),
      .cmd_full          (cmd_full),
      .cmd_push          (cmd_push),
      .cmd_data          (cmd_push_data),
      .run_count         (run_count)
   );

   // Decouple classification from emission.
   prx_cmd_fifo #(
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   // Store held bytes, drain them, and drive the result register.
   prx_back #(
      .MAX_MIN_LENGTH (MAX_MIN_LENGTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_head     (cmd_head),
      .cmd_pop      (cmd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   // An accepted end of stream always closes the run.
   `PRX_ASSERT_NEXT(a_eos_clears_run, clock, reset, req_take && req_end_of_stream, run_count == '0)
   // The back end never consumes a command that is not there.
   `PRX_ASSERT_IMPL(a_pop_needs_cmd, clock, reset, cmd_pop, cmd_valid)
   // The front end never queues into a full queue.
   `PRX_ASSERT_IMPL(a_push_not_full, clock, reset, cmd_push, !cmd_full)

endmodule

// ===== rtl/core/prx_front.sv =====
module prx_front
   import prx_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = MAX_MIN_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [MIN_LEN_W-1:0] csr_min_length,
   input  logic                 req_push,
   input  logic [DATA_W-1:0]    req_data_byte,
   input  logic                 req_end_of_stream,
   output logic                 req_full,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output cmd_type              cmd_data,
   output logic [RUN_CNT_W-1:0] run_count
);

   localparam logic [MIN_LEN_W-1:0] MIN_CAP = MIN_LEN_W'(MAX_MIN_LENGTH);

   logic [MIN_LEN_W-1:0] min_length_ff, min_length_in;
   logic [RUN_CNT_W-1:0] run_count_ff, run_count_in;
   logic [MIN_LEN_W-1:0] min_eff;
   logic [RUN_CNT_W-1:0] min_ext;
   logic                 accept;
   logic                 need_cmd;
   logic                 run_end;

   assign accept   = req_push && !cmd_full;
   assign req_full = cmd_full;
   assign cmd_push = accept && need_cmd;
   assign run_count = run_count_ff;

   assign min_length_in = csr_write_en ? csr_min_length : min_length_ff;

   always_comb begin
      min_eff = (min_length_ff == '0) ? MIN_LEN_W'(1) : min_length_ff;
      if (min_eff > MIN_CAP) begin
         min_eff = MIN_CAP;
      end
      min_ext = {1'b0, min_eff};
   end

   assign run_end = req_end_of_stream || !is_printable(req_data_byte);

   always_comb begin
      need_cmd       = 1'b0;
      cmd_data.kind  = CMD_CHAR;
      cmd_data.data  = req_data_byte;
      cmd_data.count = min_eff;
      run_count_in   = run_count_ff;
      if (run_end) begin
         // Close the run: flush held bytes plus newline, newline alone, or nothing for a short run.
         cmd_data.data = CHAR_NEWLINE;
         if (run_count_ff == min_ext) begin
            need_cmd      = 1'b1;
            cmd_data.kind = CMD_DRAIN;
         end else if (run_count_ff > min_ext) begin
            need_cmd = 1'b1;
         end
         run_count_in = '0;
      end else if (run_count_ff < min_ext) begin
         // Hold the byte until the run is long enough.
         need_cmd       = 1'b1;
         cmd_data.kind  = CMD_STORE;
         cmd_data.count = run_count_ff[MIN_LEN_W-1:0];
         run_count_in   = run_count_ff + RUN_CNT_W'(1);
      end else begin
         need_cmd      = 1'b1;
         cmd_data.kind = (run_count_ff == min_ext) ? CMD_DRAIN : CMD_CHAR;
         if (run_count_ff < RUN_CNT_MAX) begin
            run_count_in = run_count_ff + RUN_CNT_W'(1);
         end
      end
      if (!accept) begin
         run_count_in = run_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         run_count_ff  <= '0;
      end else begin
         min_length_ff <= min_length_in;
         run_count_ff  <= run_count_in;
      end
   end

endmodule

// ===== rtl/core/prx_cmd_fifo.sv =====
module prx_cmd_fifo
   import prx_pkg::*;
#(
   parameter int DEPTH = CMD_FIFO_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign valid   = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/prx_back.sv =====
module prx_back
   import prx_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = MAX_MIN_LENGTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd_head,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [DATA_W-1:0] rsp_out_char,
   output logic              rsp_last
);

   localparam int ADDR_W = (MAX_MIN_LENGTH > 1) ? $clog2(MAX_MIN_LENGTH) : 1;

   logic [DATA_W-1:0]    hold_mem [MAX_MIN_LENGTH];

   logic [MIN_LEN_W-1:0] idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_from_mem_ff, out_from_mem_in;
   logic [DATA_W-1:0]    out_lit_ff, out_lit_in;
   logic                 out_last_ff, out_last_in;
   logic [DATA_W-1:0]    rd_data_ff;

   logic advance;
   logic issue_mem;
   logic issue_lit;
   logic do_store;

   // Output register takes a new result when empty or being popped.
   assign advance = !out_valid_ff || rsp_pop;

   always_comb begin
      issue_mem = 1'b0;
      issue_lit = 1'b0;
      do_store  = 1'b0;
      if (cmd_valid) begin
         unique case (cmd_head.kind)
            CMD_STORE: begin
               do_store = 1'b1;
            end
            CMD_CHAR: begin
               issue_lit = advance;
            end
            CMD_DRAIN: begin
               if (idx_ff < cmd_head.count) begin
                  issue_mem = advance;
               end else begin
                  issue_lit = advance;
               end
            end
            default: begin
               do_store = 1'b0;
            end
         endcase
      end
   end

   assign cmd_pop = do_store || issue_lit;

   always_comb begin
      idx_in          = idx_ff;
      out_valid_in    = out_valid_ff;
      out_from_mem_in = out_from_mem_ff;
      out_lit_in      = out_lit_ff;
      out_last_in     = out_last_ff;
      if (issue_mem) begin
         idx_in = idx_ff + MIN_LEN_W'(1);
      end else if (issue_lit) begin
         idx_in = '0;
      end
      if (advance) begin
         out_valid_in    = issue_mem || issue_lit;
         out_from_mem_in = issue_mem;
         out_lit_in      = cmd_head.data;
         out_last_in     = issue_lit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_from_mem_ff <= out_from_mem_in;
      out_lit_ff      <= out_lit_in;
      out_last_ff     <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         hold_mem[cmd_head.count[ADDR_W-1:0]] <= cmd_head.data;
      end
      if (issue_mem) begin
         rd_data_ff <= hold_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_char = out_from_mem_ff ? rd_data_ff : out_lit_ff;
   assign rsp_last     = out_last_ff;

endmodule

// ===== sim/printable_run_extractor_core_test.sv =====
module printable_run_extractor_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import prx_pkg::*;

   // Watchdog: cycles in a row with no request and no result taken.
   // The longest quiet stretch of a good run is the long receiver hold.
   localparam int WATCHDOG_LIMIT   = 4000;
   // Quiet time after the last result: covers a full 64-result flush plus
   // the command queue, so trailing stores land before a register write.
   localparam int DRAIN_CYCLES     = 100;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int MAX_GAP          = 16;
   localparam int MAX_REPORTS      = 200;

   typedef struct {
      logic [DATA_W-1:0] data_byte;
      logic              end_of_stream;
   } byte_request_type;

   typedef struct {
      logic [DATA_W-1:0] out_char;
      logic              last;
   } char_result_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 csr_write_en      = 1'b0;
   logic [MIN_LEN_W-1:0] csr_min_length    = '0;
   logic                 req_push          = 1'b0;
   logic                 req_full;
   logic [DATA_W-1:0]    req_data_byte     = '0;
   logic                 req_end_of_stream = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop           = 1'b0;
   logic [DATA_W-1:0]    rsp_out_char;
   logic                 rsp_last;

   logic req_fire;
   logic rsp_fire;

   // Requests waiting for the driver, and characters the block still owes.
   byte_request_type pending_requests[$];
   char_result_type  expected_chars[$];

   int queued_count    = 0;
   int taken_count     = 0;
   int mismatch_count  = 0;
   int send_wait       = 0;
   int pop_wait        = 0;
   int stall_cycles    = 0;
   int send_gap_max    = MAX_GAP;
   int pop_gap_max     = MAX_GAP;
   int long_hold_asks  = 0;
   int long_holds_done = 0;

   // Shadow of the block: threshold register, run length and held bytes.
   logic [MIN_LEN_W-1:0] cfg_min_length = MIN_LENGTH_RESET;
   logic [RUN_CNT_W-1:0] run_len        = '0;
   logic [DATA_W-1:0]    held_bytes [0:MAX_MIN_LENGTH_DEF-1];

   printable_run_extractor_core DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_min_length    (csr_min_length),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_char      (rsp_out_char),
      .rsp_last          (rsp_last)
   );

   assign req_fire = req_push && !req_full;
   assign rsp_fire = rsp_pop && !rsp_empty;

   always #4ns clock = ~clock;

   initial begin
      foreach (held_bytes[i]) held_bytes[i] = '0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic printable_byte(input logic [DATA_W-1:0] c);
      return c inside {CHAR_TAB, [PRINTABLE_LO:PRINTABLE_HI]};
   endfunction

   // A zero threshold acts as one.
   function automatic int effective_min(input logic [MIN_LEN_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
   endfunction

   // Advance the shadow state by one request and queue the characters it owes.
   task automatic predict_request(input logic [DATA_W-1:0] b, input logic eos);
      logic [DATA_W-1:0] burst[$];
      char_result_type   r;
      int                m;
      m = effective_min(cfg_min_length);
      if (eos || !printable_byte(b)) begin
         // Close the run: one that stopped right at the threshold still
         // owes its held bytes; a shorter one is dropped silently.
         if (int'(run_len) == m) begin
            for (int i = 0; i < m; i++) burst.push_back(held_bytes[i]);
            burst.push_back(CHAR_NEWLINE);
         end else if (int'(run_len) > m) begin
            burst.push_back(CHAR_NEWLINE);
         end
         run_len = '0;
      end else if (int'(run_len) < m) begin
         held_bytes[run_len] = b;
         run_len = run_len + 1'b1;
      end else begin
         // The byte past the threshold releases the held bytes first;
         // later bytes pass straight through.
         if (int'(run_len) == m) begin
            for (int i = 0; i < m; i++) burst.push_back(held_bytes[i]);
         end
         burst.push_back(b);
         if (run_len != RUN_CNT_MAX) run_len = run_len + 1'b1;
      end
      foreach (burst[i]) begin
         r.out_char = burst[i];
         r.last     = (i == burst.size() - 1);
         expected_chars.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Request driver: pop pending requests, hold each until taken.
   // ------------------------------------------------------------------

   always @(posedge clock) begin : drive_requests
      byte_request_type nxt;
      if (reset) begin
         req_push  <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_fire) begin
            predict_request(req_data_byte, req_end_of_stream);
            taken_count++;
         end
         if (req_push && !req_fire) begin
            // hold the request on the bus until the block has room
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_push  <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            nxt = pending_requests.pop_front();
            req_data_byte     <= nxt.data_byte;
            req_end_of_stream <= nxt.end_of_stream;
            req_push          <= 1'b1;
            send_wait         <= $urandom_range(0, send_gap_max);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: check each popped character against the oldest
   // expectation, then draw how long to wait before the next pop.
   // ------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      char_result_type want;
      int              gap;
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_wait <= 0;
      end else begin
         if (rsp_fire) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                         rsp_out_char, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.out_char)
                  report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                            rsp_out_char, want.out_char));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                            rsp_last, want.last, want.out_char));
            end
         end
         if (long_holds_done != long_hold_asks) begin
            // Stop popping for a long stretch so the block backs up.
            long_holds_done++;
            pop_wait <= LONG_HOLD_CYCLES;
            rsp_pop  <= 1'b0;
         end else if (rsp_fire) begin
            gap = $urandom_range(0, pop_gap_max);
            pop_wait <= gap;
            rsp_pop  <= (gap == 0);
         end else if (pop_wait > 0) begin
            pop_wait <= pop_wait - 1;
            rsp_pop  <= (pop_wait == 1);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Drop the run when nothing moves on either side for too long.
   always @(posedge clock) begin : watchdog
      if (reset || req_fire || rsp_fire) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   task automatic queue_request(input logic [DATA_W-1:0] b, input logic eos);
      byte_request_type r;
      r.data_byte     = b;
      r.end_of_stream = eos;
      pending_requests.push_back(r);
      queued_count++;
   endtask

   function automatic logic [DATA_W-1:0] rand_printable();
      if ($urandom_range(0, 15) == 0) return CHAR_TAB;
      return DATA_W'($urandom_range(int'(PRINTABLE_LO), int'(PRINTABLE_HI)));
   endfunction

   // Any byte that ends a run: controls, newline, DEL and the upper half.
   function automatic logic [DATA_W-1:0] rand_breaker();
      logic [DATA_W-1:0] c;
      c = DATA_W'($urandom_range(0, 255));
      while (printable_byte(c)) c = DATA_W'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic queue_printables(input int n);
      repeat (n) queue_request(rand_printable(), 1'b0);
   endtask

   // Mostly well-formed runs sized around the threshold (short, exact, one
   // over, well over), each closed by a breaker or an end of stream; the
   // rest is raw noise.
   task automatic queue_random_runs(input int target);
      int added;
      int kind;
      int len;
      int m;
      added = 0;
      m     = effective_min(cfg_min_length);
      while (added < target) begin
         kind = $urandom_range(0, 9);
         if (kind >= 8) begin
            len = $urandom_range(1, 4);
            repeat (len) queue_request(DATA_W'($urandom_range(0, 255)), 1'b0);
            added += len;
         end else begin
            if (kind < 2)      len = $urandom_range(0, m - 1);
            else if (kind < 4) len = m;
            else if (kind < 5) len = m + 1;
            else               len = m + $urandom_range(2, 12);
            queue_printables(len);
            if ($urandom_range(0, 3) == 0)
               queue_request(DATA_W'($urandom_range(0, 255)), 1'b1);
            else
               queue_request(rand_breaker(), 1'b0);
            added += len + 1;
         end
      end
   endtask

   // Pause the sender until every owed character is in, then let trailing
   // stores settle.
   task automatic wait_until_idle();
      while (taken_count != queued_count || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_length(input logic [MIN_LEN_W-1:0] v);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_min_length <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg_min_length = v;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin : run_sequence
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset threshold of 4.
      // Run of exactly four with both printable edges and a tab, closed by DEL.
      queue_request(PRINTABLE_LO, 1'b0);
      queue_request(PRINTABLE_HI, 1'b0);
      queue_request(CHAR_TAB, 1'b0);
      queue_request(8'h41, 1'b0);
      queue_request(8'h7F, 1'b0);
      // Lone control byte just below the printable range.
      queue_request(8'h1F, 1'b0);
      // Short run dropped by 0xFF.
      queue_request(8'h61, 1'b0);
      queue_request(8'h62, 1'b0);
      queue_request(8'h63, 1'b0);
      queue_request(8'hFF, 1'b0);
      // Run past the threshold: burst on the fifth, pass-through, newline close.
      queue_request(8'h30, 1'b0);
      queue_request(8'h31, 1'b0);
      queue_request(8'h32, 1'b0);
      queue_request(8'h33, 1'b0);
      queue_request(8'h34, 1'b0);
      queue_request(8'h35, 1'b0);
      queue_request(CHAR_NEWLINE, 1'b0);
      // Exact-length run flushed by end of stream; its data byte is ignored.
      repeat (4) queue_request(8'h41, 1'b0);
      queue_request(8'h41, 1'b1);
      // End of stream with no run pending, then a backspace.
      queue_request(8'hFF, 1'b1);
      queue_request(8'h08, 1'b0);
      wait_until_idle();

      // Smallest threshold, random gaps on both sides.
      write_min_length(6'd1);
      queue_random_runs(30);
      wait_until_idle();

      // Zero threshold, no idling on either side.
      send_gap_max = 0;
      pop_gap_max  = 0;
      write_min_length(6'd0);
      queue_random_runs(20);
      wait_until_idle();

      // One very long run that saturates the run counter, pushed back-to-back
      // while the receiver holds off, so the block fills and stalls requests.
      pop_gap_max = MAX_GAP;
      write_min_length(6'd2);
      long_hold_asks++;
      queue_printables(135);
      queue_request(rand_breaker(), 1'b0);
      wait_until_idle();

      // Largest threshold: an exact-length run and a run one longer closed by
      // end of stream, both bursting every held byte.
      send_gap_max = MAX_GAP;
      write_min_length(6'd63);
      queue_printables(63);
      queue_request(rand_breaker(), 1'b0);
      queue_printables(64);
      queue_request(DATA_W'($urandom_range(0, 255)), 1'b1);
      wait_until_idle();

      // Leave a run open across each of the next threshold changes.
      write_min_length(6'd7);
      queue_random_runs(30);
      queue_printables(5);
      wait_until_idle();

      write_min_length(6'd3);
      queue_random_runs(20);
      queue_printables(2);
      wait_until_idle();

      write_min_length(MIN_LEN_W'($urandom_range(1, 12)));
      queue_random_runs(30);
      queue_request(DATA_W'($urandom_range(0, 255)), 1'b1);
      wait_until_idle();

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/prx_pkg.sv
rtl/core/prx_front.sv
rtl/core/prx_cmd_fifo.sv
rtl/core/prx_back.sv
rtl/core/printable_run_extractor_core.sv
sim/printable_run_extractor_core_test.sv
